// ----- hdl/hcp_pkg.sv -----
package hcp_pkg;

   localparam int CharWidth   = 8;
   localparam int CountWidth  = 4;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 3;
   localparam int CsrIdxWidth = 2;
   localparam int RspWidth    = 40;

   localparam logic [CharWidth-1:0]   CHAR_HASH   = 8'h23;
   localparam logic [CountWidth-1:0]  MAX_SHIFT   = 4'd8;
   localparam logic [CountWidth-1:0]  COUNT_SAT   = 4'd9;
   localparam logic [CountWidth-1:0]  LIMIT_RGBA  = 4'd8;
   localparam logic [CountWidth-1:0]  LIMIT_RGB   = 4'd6;

   localparam logic [StatusWidth-1:0] ST_OK     = 3'd0;
   localparam logic [StatusWidth-1:0] ST_LONG   = 3'd1;
   localparam logic [StatusWidth-1:0] ST_DIGIT  = 3'd2;
   localparam logic [StatusWidth-1:0] ST_LENGTH = 3'd3;
   localparam logic [StatusWidth-1:0] ST_ALPHA  = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_FOUR_COMPONENT = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_REQUIRE_ALPHA  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PERMISSIVE     = 2'd2;

   typedef struct packed {
      logic four_component;
      logic require_alpha;
      logic permissive;
   } cfg_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [7:0]             alpha;
      logic [7:0]             blue;
      logic [7:0]             green;
      logic [7:0]             red;
   } color_type;

endpackage

// ----- hdl/hcp_decode.sv -----
// Final decode of the collected digits into a color and a status.
module hcp_decode (
   input  hcp_pkg::cfg_type                     cfg,
   input  logic                                 empty_string,
   input  logic [hcp_pkg::ValueWidth-1:0]       value,
   input  logic [hcp_pkg::CountWidth-1:0]       count,
   input  logic                                 bad_digit,
   output hcp_pkg::color_type                   color
);

   logic                           req_alpha;
   logic [hcp_pkg::CountWidth-1:0] limit;
   hcp_pkg::color_type             err;

   assign req_alpha = cfg.four_component & cfg.require_alpha;
   assign limit     = cfg.four_component ? hcp_pkg::LIMIT_RGBA : hcp_pkg::LIMIT_RGB;

   always_comb begin
      err        = '0;
      color      = '0;
      color.status = hcp_pkg::ST_LENGTH;
      priority if (empty_string) begin
         if (cfg.permissive) begin
            color.red    = 8'hFF;
            color.green  = 8'hFF;
            color.blue   = 8'hFF;
            color.alpha  = 8'hFF;
            color.status = hcp_pkg::ST_OK;
         end else begin
            color        = err;
            color.status = hcp_pkg::ST_DIGIT;
         end
      end else if (count > limit) begin
         color.status = hcp_pkg::ST_LONG;
      end else if (bad_digit || count == '0) begin
         color.status = hcp_pkg::ST_DIGIT;
      end else begin
         unique case (count)
            4'd8: begin
               // only reachable in RGBA mode, the length check catches the rest
               color.red    = value[31:24];
               color.green  = value[23:16];
               color.blue   = value[15:8];
               color.alpha  = value[7:0];
               color.status = hcp_pkg::ST_OK;
            end
            4'd6: begin
               if (req_alpha) begin
                  color.status = hcp_pkg::ST_ALPHA;
               end else begin
                  color.red    = value[23:16];
                  color.green  = value[15:8];
                  color.blue   = value[7:0];
                  color.alpha  = 8'hFF;
                  color.status = hcp_pkg::ST_OK;
               end
            end
            4'd4: begin
               if (cfg.four_component) begin
                  // nibble * 17 is the nibble repeated
                  color.red    = {value[15:12], value[15:12]};
                  color.green  = {value[11:8], value[11:8]};
                  color.blue   = {value[7:4], value[7:4]};
                  color.alpha  = {value[3:0], value[3:0]};
                  color.status = hcp_pkg::ST_OK;
               end
            end
            4'd3: begin
               if (req_alpha) begin
                  color.status = hcp_pkg::ST_ALPHA;
               end else begin
                  color.red    = {value[11:8], value[11:8]};
                  color.green  = {value[7:4], value[7:4]};
                  color.blue   = {value[3:0], value[3:0]};
                  color.alpha  = 8'hFF;
                  color.status = hcp_pkg::ST_OK;
               end
            end
            4'd2, 4'd1: begin
               if (!cfg.permissive) begin
                  color.status = hcp_pkg::ST_LENGTH;
               end else if (req_alpha) begin
                  color.status = hcp_pkg::ST_ALPHA;
               end else begin
                  color.red    = (count == 4'd2) ? value[7:0] : {value[3:0], value[3:0]};
                  color.green  = color.red;
                  color.blue   = color.red;
                  color.alpha  = 8'hFF;
                  color.status = hcp_pkg::ST_OK;
               end
            end
            default: begin
               color.status = hcp_pkg::ST_LENGTH;
            end
         endcase
      end
   end

endmodule

// ----- hdl/hex_color_string_parser.sv -----
// Hex color string parser. One character is taken per cycle on req_ (tlast marks the end of
// the string, tuser flags an empty string); the beat that ends a string produces one result
// beat on rsp_ in the next cycle, holding red, green, blue, alpha and a status. A new string
// may start on the very next beat, so the sustained rate is one character per clock, set
// by the combinational digit accumulator; the only stall comes from rsp_tready through the
// one-entry output register. Configuration writes on csr_ must happen while no string is in
// progress.
module hex_color_string_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [hcp_pkg::CharWidth-1:0]          req_tdata,  // [7:0] ch
   input  logic                                   req_tlast,
   input  logic                                   req_tuser,  // [0] empty_string
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [34:32] status, rest zero
   output logic [hcp_pkg::RspWidth-1:0]           rsp_tdata,
   input  logic                                   csr_we,
   input  logic [hcp_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic                                   csr_wdata
);

   hcp_pkg::cfg_type               cfg_ff;
   logic [hcp_pkg::ValueWidth-1:0] value_ff, value_in;
   logic [hcp_pkg::CountWidth-1:0] count_ff, count_in;
   logic                           bad_ff, bad_in;
   logic                           start_ff, start_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   hcp_pkg::color_type             rsp_color_ff, rsp_color_in;
   logic                           req_beat;
   logic                           done;
   logic                           nib_ok;
   logic [3:0]                     nib;
   logic [hcp_pkg::ValueWidth-1:0] acc_value;
   logic [hcp_pkg::CountWidth-1:0] acc_count;
   logic                           acc_bad;
   hcp_pkg::color_type             color;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign done       = req_tlast || req_tuser;

   always_comb begin
      nib_ok = 1'b1;
      nib    = 4'd0;
      priority if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         nib = 4'(req_tdata - 8'h30);
      end else if (req_tdata >= 8'h41 && req_tdata <= 8'h46) begin
         nib = 4'(req_tdata - 8'h37);
      end else if (req_tdata >= 8'h61 && req_tdata <= 8'h66) begin
         nib = 4'(req_tdata - 8'h57);
      end else begin
         nib_ok = 1'b0;
      end
   end

   always_comb begin
      acc_value = value_ff;
      acc_count = count_ff;
      acc_bad   = bad_ff;
      if (!(start_ff && req_tdata == hcp_pkg::CHAR_HASH)) begin
         if (!nib_ok) begin
            acc_bad = 1'b1;
         end
         if (count_ff < hcp_pkg::MAX_SHIFT && nib_ok) begin
            acc_value = {value_ff[hcp_pkg::ValueWidth-5:0], nib};
         end
         if (count_ff < hcp_pkg::COUNT_SAT) begin
            acc_count = count_ff + 4'd1;
         end
      end
   end

   hcp_decode u_decode (
      .cfg          (cfg_ff),
      .empty_string (req_tuser),
      .value        (acc_value),
      .count        (acc_count),
      .bad_digit    (acc_bad),
      .color        (color)
   );

   always_comb begin
      value_in     = value_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_color_in = rsp_color_ff;
      if (req_beat) begin
         if (done) begin
            value_in     = '0;
            count_in     = '0;
            bad_in       = 1'b0;
            start_in     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_color_in = color;
         end else begin
            value_in = acc_value;
            count_in = acc_count;
            bad_in   = acc_bad;
            start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff     <= '0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{four_component: 1'b1, require_alpha: 1'b0, permissive: 1'b0};
      end else begin
         value_ff     <= value_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               hcp_pkg::CSR_FOUR_COMPONENT: cfg_ff.four_component <= csr_wdata;
               hcp_pkg::CSR_REQUIRE_ALPHA:  cfg_ff.require_alpha  <= csr_wdata;
               hcp_pkg::CSR_PERMISSIVE:     cfg_ff.permissive     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_color_ff};

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hcp_pkg::COUNT_SAT)
      else $error("digit count beyond saturation");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      req_beat && done |=> count_ff == '0 && start_ff && !bad_ff && rsp_tvalid)
      else $error("state not cleared or no result after end of string");

   a_mid_not_start: assert property (@(posedge clock) disable iff (reset)
      req_beat && !done |=> !start_ff && !rsp_tvalid || !start_ff)
      else $error("start flag still set after a character");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] != hcp_pkg::ST_OK |-> rsp_tdata[31:0] == '0)
      else $error("error result carries nonzero components");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= hcp_pkg::ST_ALPHA && rsp_tdata[39:35] == '0)
      else $error("status code out of range");

endmodule
